// File: rtl/aabt_pkg.sv
// Package for the aging address block table: field widths, request and status codes, control structs.
`default_nettype none
package aabt_pkg;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned TIME_W = 31;
	localparam int unsigned STEP_W = 16;
	localparam int unsigned REQ_W = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOT_W = 6;
	localparam int unsigned EXP_W = 7;

	localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd3600;
	localparam int unsigned TABLE_DEPTH_DEF = 64;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_TICK   = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic commit;
		logic rsp_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_end;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/aabt_if.sv
// Request and response channel interfaces of the aging address block table.
`default_nettype none
interface aabt_req_if;
	logic                            valid;
	logic                            ready;
	logic [aabt_pkg::REQ_W-1:0]      req_type;
	logic [aabt_pkg::KEY_W-1:0]      key;
	logic [aabt_pkg::TIME_W-1:0]     duration;
	logic                            permanent;

	modport source (output valid, output req_type, output key, output duration,
		output permanent, input ready);
	modport sink (input valid, input req_type, input key, input duration,
		input permanent, output ready);
endinterface

interface aabt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [aabt_pkg::STATUS_W-1:0]     status;
	logic                              hit;
	logic [aabt_pkg::SLOT_W-1:0]       slot;
	logic [aabt_pkg::EXP_W-1:0]        expired_count;

	modport source (output valid, output status, output hit, output slot,
		output expired_count, input ready);
	modport sink (input valid, input status, input hit, input slot,
		input expired_count, output ready);
endinterface
`default_nettype wire

// File: rtl/aging_address_block_table.sv
// Top level of the aging address block table.
`default_nettype none
// The aging address block table keeps TABLE_DEPTH slots, each a 32-bit address key with a
// valid mark, a permanent mark and a remaining time, and answers one request at a time:
// add, delete, lookup and tick aging. Every request walks the whole slot memory through
// its single read port, one slot per cycle. After the walk the read pipeline drains, the
// controller confirms the walk is over, an add is committed and the answer is loaded. The
// result sits in an output register, so the next request is taken while it still waits;
// if it is still waiting when that next walk ends, the new answer is held back until the
// sink takes the old one. Delete and tick write each slot back right behind the read, and
// add stores the new key in the commit step after the walk. After reset a clearing pass
// marks every slot free, and no request is taken until it ends. The tick step register
// may be written at any time the table is idle; it takes effect on the next tick.
module aging_address_block_table #(
	parameter int unsigned TABLE_DEPTH = aabt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	aabt_req_if.sink                           req,
	aabt_rsp_if.source                         rsp,
	input  wire logic                          tick_step_we,
	input  wire logic [aabt_pkg::STEP_W-1:0]   tick_step_wdata
);

	aabt_pkg::cmd_t  cmd;
	aabt_pkg::stat_t stat;

	// The controller sequences clearing, scanning, committing and answering.
	aabt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the slot memory, the scan pipeline and the result register.
	aabt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.tick_step_we    (tick_step_we),
		.tick_step_wdata (tick_step_wdata),
		.req_type        (req.req_type),
		.key             (req.key),
		.duration        (req.duration),
		.permanent       (req.permanent),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.status          (rsp.status),
		.hit             (rsp.hit),
		.slot            (rsp.slot),
		.expired_count   (rsp.expired_count)
	);

endmodule
`default_nettype wire

// File: rtl/aabt_ctrl.sv
// Controller state machine of the aging address block table.
`default_nettype none
module aabt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire aabt_pkg::stat_t stat,
	output aabt_pkg::cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_COMMIT = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.cnt_end) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.rsp_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	// Whenever the controller waits for a request, the slot counter has run to the end.
	a_idle_cnt_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> stat.cnt_end)
		else $error("idle with slot counter not at end");

	// A freshly loaded request cannot finish its scan in the next cycle.
	a_scan_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !stat.scan_done)
		else $error("scan reported done right after load");

endmodule
`default_nettype wire

// File: rtl/aabt_dp.sv
// Datapath of the aging address block table: entry memory, scan pipeline, result register.
`default_nettype none
module aabt_dp #(
	parameter int unsigned TABLE_DEPTH = aabt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire aabt_pkg::cmd_t                   cmd,
	output aabt_pkg::stat_t                       stat,
	input  wire logic                             tick_step_we,
	input  wire logic [aabt_pkg::STEP_W-1:0]      tick_step_wdata,
	input  wire logic [aabt_pkg::REQ_W-1:0]       req_type,
	input  wire logic [aabt_pkg::KEY_W-1:0]       key,
	input  wire logic [aabt_pkg::TIME_W-1:0]      duration,
	input  wire logic                             permanent,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output logic [aabt_pkg::STATUS_W-1:0]         status,
	output logic                                  hit,
	output logic [aabt_pkg::SLOT_W-1:0]           slot,
	output logic [aabt_pkg::EXP_W-1:0]            expired_count
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned SLOT_EXT_W = AW + aabt_pkg::SLOT_W;
	localparam int unsigned EXP_EXT_W = CW + aabt_pkg::EXP_W;
	localparam logic [CW-1:0] CNT_END = CW'(TABLE_DEPTH);

	typedef struct packed {
		logic                          valid;
		logic                          perm;
		logic [aabt_pkg::TIME_W-1:0]   ttl;
		logic [aabt_pkg::KEY_W-1:0]    key;
	} entry_t;

	entry_t mem [TABLE_DEPTH];

	logic [aabt_pkg::STEP_W-1:0] step_q;
	aabt_pkg::req_type_t         req_type_q;
	logic [aabt_pkg::KEY_W-1:0]  key_q;
	logic [aabt_pkg::TIME_W-1:0] dur_q;
	logic                        perm_q;

	logic [CW-1:0] cnt_q;
	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	entry_t        rdata_s1;

	logic          hit_q;
	logic [AW-1:0] match_idx_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;
	logic [CW-1:0] exp_q;

	logic          rsp_valid_q;
	logic [aabt_pkg::STATUS_W-1:0] status_q;
	logic          hit_out_q;
	logic [aabt_pkg::SLOT_W-1:0]   slot_q;
	logic [aabt_pkg::EXP_W-1:0]    exp_out_q;

	logic is_add, is_del, is_tick;
	logic cnt_run, rd_en, clr_wr, add_wr, wb_en;
	logic match_s1, expire_s1;
	logic [aabt_pkg::TIME_W-1:0] step_ext, aged_s1;
	entry_t wb_data, add_data;

	aabt_pkg::status_t       nxt_status;
	logic                    nxt_hit;
	logic [AW-1:0]           nxt_idx;
	logic [SLOT_EXT_W-1:0]   slot_ext;
	logic [EXP_EXT_W-1:0]    exp_ext;

	assign is_add  = (req_type_q == aabt_pkg::REQ_ADD);
	assign is_del  = (req_type_q == aabt_pkg::REQ_DELETE);
	assign is_tick = (req_type_q == aabt_pkg::REQ_TICK);

	assign cnt_run = (cnt_q != CNT_END);
	assign rd_en   = cmd.scan && cnt_run;
	assign clr_wr  = cmd.clear && cnt_run;
	assign add_wr  = cmd.commit && is_add && !hit_q && free_q;

	// Aging and delete write-back of the entry read in the previous cycle.
	always_comb begin
		step_ext  = aabt_pkg::TIME_W'(step_q);
		aged_s1   = (rdata_s1.ttl > step_ext) ? (rdata_s1.ttl - step_ext) : '0;
		match_s1  = rdata_s1.valid && (rdata_s1.key == key_q);
		expire_s1 = rdata_s1.valid && !rdata_s1.perm && (aged_s1 == '0);
		wb_data   = rdata_s1;
		if (is_tick) begin
			if (rdata_s1.valid && !rdata_s1.perm) begin
				wb_data.ttl = aged_s1;
			end
			if (expire_s1) begin
				wb_data.valid = 1'b0;
			end
		end else if (match_s1) begin
			wb_data.valid = 1'b0;
		end
		wb_en = valid_s1 && (is_tick || is_del);
	end

	always_comb begin
		add_data.valid = 1'b1;
		add_data.perm  = perm_q;
		add_data.ttl   = dur_q;
		add_data.key   = key_q;
	end

	always_ff @(posedge clk) begin
		priority if (clr_wr) begin
			mem[cnt_q[AW-1:0]] <= '0;
		end else if (add_wr) begin
			mem[free_idx_q] <= add_data;
		end else if (wb_en) begin
			mem[addr_s1] <= wb_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[cnt_q[AW-1:0]];
		end
		if (rd_en) begin
			addr_s1 <= cnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= aabt_pkg::TICK_STEP_RESET;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			exp_q    <= '0;
		end else begin
			if (tick_step_we) begin
				step_q <= tick_step_wdata;
			end
			valid_s1 <= rd_en;
			if (cmd.load) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				exp_q  <= '0;
			end else begin
				if (rd_en || clr_wr) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (valid_s1 && match_s1) begin
					hit_q <= 1'b1;
				end
				if (valid_s1 && !rdata_s1.valid) begin
					free_q <= 1'b1;
				end
				if (valid_s1 && is_tick && expire_s1) begin
					exp_q <= exp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= aabt_pkg::req_type_t'(req_type);
			key_q      <= key;
			dur_q      <= duration;
			perm_q     <= permanent;
		end
		if (valid_s1 && match_s1 && !hit_q) begin
			match_idx_q <= addr_s1;
		end
		if (valid_s1 && !rdata_s1.valid && !free_q) begin
			free_idx_q <= addr_s1;
		end
	end

	// Result of the request from the scan summary.
	always_comb begin
		nxt_status = aabt_pkg::ST_DONE;
		nxt_hit    = 1'b0;
		nxt_idx    = '0;
		unique case (req_type_q)
			aabt_pkg::REQ_ADD: begin
				if (hit_q) begin
					nxt_status = aabt_pkg::ST_PRESENT;
					nxt_hit    = 1'b1;
					nxt_idx    = match_idx_q;
				end else if (!free_q) begin
					nxt_status = aabt_pkg::ST_FULL;
				end else begin
					nxt_idx = free_idx_q;
				end
			end
			aabt_pkg::REQ_DELETE, aabt_pkg::REQ_LOOKUP: begin
				if (hit_q) begin
					nxt_hit = 1'b1;
					nxt_idx = match_idx_q;
				end else begin
					nxt_status = aabt_pkg::ST_NOT_FOUND;
				end
			end
			aabt_pkg::REQ_TICK: begin
				nxt_status = aabt_pkg::ST_DONE;
			end
			default: begin
				nxt_status = aabt_pkg::ST_DONE;
			end
		endcase
		slot_ext = SLOT_EXT_W'(nxt_idx);
		exp_ext  = EXP_EXT_W'(exp_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			status_q  <= nxt_status;
			hit_out_q <= nxt_hit;
			slot_q    <= slot_ext[aabt_pkg::SLOT_W-1:0];
			exp_out_q <= exp_ext[aabt_pkg::EXP_W-1:0];
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign hit           = hit_out_q;
	assign slot          = slot_q;
	assign expired_count = exp_out_q;

	assign stat.cnt_end   = !cnt_run;
	assign stat.scan_done = !cnt_run && !valid_s1;
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

	// Clearing, insertion and write-back never share the single write port.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({clr_wr, add_wr, wb_en}))
		else $error("memory write port collision");

	// A tick can free no more entries than the table holds.
	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q <= CNT_END)
		else $error("expired count beyond table depth");

endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the aging address block table: directed and random requests.
`timescale 1ns / 100ps
module tb;
	import aabt_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	// Longest random wait of either side, in cycles.
	localparam int STALL_MAX = 16;
	// The limit allows for many times the usual gap between moving items.
	localparam int IDLE_LIMIT = 2000;
	localparam int POOL_SIZE = 96;
	// The block is idle once its last answer is taken; wait a full walk more as margin.
	localparam int SETTLE_CYCLES = DEPTH + 16;

	typedef struct {
		req_type_t        kind;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] duration;
		logic              permanent;
	} request_t;

	typedef struct {
		status_t            status;
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [EXP_W-1:0]   expired_count;
	} answer_t;

	logic              clk;
	logic              arst_n;
	logic              step_we;
	logic [STEP_W-1:0] step_wdata;

	aabt_req_if req_ch();
	aabt_rsp_if rsp_ch();

	aging_address_block_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.tick_step_we    (step_we),
		.tick_step_wdata (step_wdata)
	);

	// Shadow copy of the table and of the tick step, kept in step with accepted items.
	logic [KEY_W-1:0]  shadow_key   [DEPTH];
	logic              shadow_valid [DEPTH];
	logic              shadow_perm  [DEPTH];
	logic [TIME_W-1:0] shadow_time  [DEPTH];
	logic [STEP_W-1:0] shadow_step;

	// Answers still owed by the block, oldest first.
	answer_t pending_answers[$];

	// Random keys come mostly from this pool so that adds, deletes and lookups meet.
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	bit gaps_on = 1'b1;
	int errors = 0;
	int rsp_stall = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Applies one request to the shadow table and returns the answer the block must give.
	function automatic answer_t apply_request(request_t rq);
		answer_t ans;
		int match;
		int free_slot;
		ans = '{status: ST_DONE, hit: 1'b0, slot: '0, expired_count: '0};
		match = -1;
		free_slot = -1;
		if (rq.kind == REQ_TICK) begin
			// Timed entries age by the step and stop at zero; an entry at zero is freed,
			// which also covers entries added with no time at all. Permanent ones never age.
			for (int i = 0; i < DEPTH; i++) begin
				if (shadow_valid[i] && !shadow_perm[i]) begin
					if (shadow_time[i] != '0) begin
						if (shadow_time[i] > shadow_step)
							shadow_time[i] = shadow_time[i] - shadow_step;
						else
							shadow_time[i] = '0;
					end
					if (shadow_time[i] == '0) begin
						shadow_valid[i] = 1'b0;
						ans.expired_count++;
					end
				end
			end
		end else begin
			// The hit and the slot come from the table as it stood when the item arrived.
			for (int i = 0; i < DEPTH; i++)
				if (match < 0 && shadow_valid[i] && shadow_key[i] == rq.key)
					match = i;
			if (match >= 0) begin
				ans.hit = 1'b1;
				ans.slot = SLOT_W'(match);
			end
			case (rq.kind)
			REQ_ADD: begin
				if (match >= 0) begin
					ans.status = ST_PRESENT;
				end else begin
					for (int i = 0; i < DEPTH; i++)
						if (free_slot < 0 && !shadow_valid[i])
							free_slot = i;
					if (free_slot < 0) begin
						ans.status = ST_FULL;
					end else begin
						shadow_key[free_slot] = rq.key;
						shadow_valid[free_slot] = 1'b1;
						shadow_perm[free_slot] = rq.permanent;
						shadow_time[free_slot] = rq.duration;
						ans.slot = SLOT_W'(free_slot);
					end
				end
			end
			default: begin
				if (match < 0) begin
					ans.status = ST_NOT_FOUND;
				end else if (rq.kind == REQ_DELETE) begin
					for (int i = 0; i < DEPTH; i++)
						if (shadow_valid[i] && shadow_key[i] == rq.key)
							shadow_valid[i] = 1'b0;
				end
			end
			endcase
		end
		return ans;
	endfunction

	// Offers one item after a random gap and records its answer once the block takes it.
	// The task is always entered right after a rising edge, and valid is left high on
	// return so that a following item with no gap needs only one assignment to it.
	task automatic send_item(request_t rq);
		int gap;
		gap = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= rq.kind;
		req_ch.key       <= rq.key;
		req_ch.duration  <= rq.duration;
		req_ch.permanent <= rq.permanent;
		do
			@(posedge clk);
		while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
		pending_answers.push_back(apply_request(rq));
	endtask

	// Withdraws the request channel so that the held item is not taken a second time.
	task automatic drop_req();
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// The step may only change while the table is idle, so every answer is collected first.
	task automatic write_step(logic [STEP_W-1:0] value);
		drop_req();
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		step_we    <= 1'b1;
		step_wdata <= value;
		@(posedge clk);
		step_we <= 1'b0;
		shadow_step = value;
	endtask

	// Draws one request; the three weights are percentages and ticks take the rest.
	function automatic request_t random_request(int add_pct, int del_pct, int look_pct);
		request_t rq;
		int pick;
		logic [31:0] raw;
		pick = $urandom_range(0, 99);
		if (pick < add_pct)
			rq.kind = REQ_ADD;
		else if (pick < add_pct + del_pct)
			rq.kind = REQ_DELETE;
		else if (pick < add_pct + del_pct + look_pct)
			rq.kind = REQ_LOOKUP;
		else
			rq.kind = REQ_TICK;
		if ($urandom_range(0, 99) < 85)
			rq.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			rq.key = $urandom;
		// Mostly short times that a few ticks use up, with zero, full-range and maximal ones.
		raw = $urandom;
		case ($urandom_range(0, 9))
		0: rq.duration = '0;
		1: rq.duration = '1;
		2, 3: rq.duration = raw[TIME_W-1:0];
		default: rq.duration = TIME_W'($urandom_range(1, 20000));
		endcase
		rq.permanent = ($urandom_range(0, 4) == 0);
		return rq;
	endfunction

	// Random traffic in stretches of 50 items, most with idling and some without.
	task automatic run_random(int count, int add_pct, int del_pct, int look_pct);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			send_item(random_request(add_pct, del_pct, look_pct));
		end
	endtask

	// Short hand-written sequence on the empty table at the reset step of 3600 seconds.
	task automatic test_directed();
		gaps_on = 1'b1;
		// Lookup, delete and tick on an empty table.
		send_item('{REQ_LOOKUP, 32'h0000_0000, 31'd0, 1'b0});
		send_item('{REQ_DELETE, 32'hFFFF_FFFF, 31'd0, 1'b0});
		send_item('{REQ_TICK, 32'h0000_0000, 31'd0, 1'b0});
		// Extremes of key and time; one entry with no time, one permanent with the most.
		send_item('{REQ_ADD, 32'h0000_0000, 31'd0, 1'b0});
		send_item('{REQ_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1});
		send_item('{REQ_ADD, 32'h5555_AAAA, 31'd3600, 1'b0});
		send_item('{REQ_ADD, 32'hAAAA_5555, 31'd3601, 1'b0});
		// A key that is already present is not stored twice.
		send_item('{REQ_ADD, 32'h0000_0000, 31'd77, 1'b1});
		send_item('{REQ_LOOKUP, 32'hFFFF_FFFF, 31'd0, 1'b0});
		// This tick frees the zero-time entry and the one that lands exactly on zero.
		send_item('{REQ_TICK, 32'h1234_5678, 31'h7FFF_FFFF, 1'b1});
		send_item('{REQ_LOOKUP, 32'h0000_0000, 31'd0, 1'b0});
		// The lowest free slot is reused.
		send_item('{REQ_ADD, 32'h1234_5678, 31'd1, 1'b1});
		// The remaining second is clamped at zero rather than wrapping.
		send_item('{REQ_TICK, 32'h0000_0000, 31'd0, 1'b0});
		send_item('{REQ_DELETE, 32'h1234_5678, 31'd0, 1'b0});
		send_item('{REQ_LOOKUP, 32'h1234_5678, 31'd0, 1'b0});
		send_item('{REQ_DELETE, 32'hFFFF_FFFF, 31'd0, 1'b0});
		send_item('{REQ_TICK, 32'hFFFF_FFFF, 31'd0, 1'b0});
		// A permanent entry with no time left must survive a tick.
		send_item('{REQ_ADD, 32'hFFFF_FFFF, 31'd0, 1'b1});
		send_item('{REQ_TICK, 32'h0000_0000, 31'd0, 1'b0});
		send_item('{REQ_LOOKUP, 32'hFFFF_FFFF, 31'd0, 1'b0});
		send_item('{REQ_DELETE, 32'hFFFF_FFFF, 31'd0, 1'b0});
	endtask

	// Fills every slot, tries more adds against the full table, then empties it again.
	task automatic test_fill_table();
		gaps_on = 1'b1;
		for (int i = 0; i < DEPTH + 2; i++)
			send_item('{REQ_ADD, {8'hA5, 24'(i * 977)}, 31'(i * 1000), i[0]});
		send_item('{REQ_ADD, {8'hA5, 24'(0)}, 31'd5, 1'b0});
		send_item('{REQ_ADD, 32'h0BAD_F00D, 31'd5, 1'b0});
		send_item('{REQ_LOOKUP, {8'hA5, 24'((DEPTH - 1) * 977)}, 31'd0, 1'b0});
		send_item('{REQ_LOOKUP, 32'h0BAD_F00D, 31'd0, 1'b0});
		send_item('{REQ_TICK, 32'h0000_0000, 31'd0, 1'b0});
		send_item('{REQ_ADD, 32'h0BAD_F00D, 31'd5, 1'b0});
		gaps_on = 1'b0;
		for (int i = 0; i < DEPTH + 2; i++)
			send_item('{REQ_DELETE, {8'hA5, 24'(i * 977)}, 31'd0, 1'b0});
		send_item('{REQ_DELETE, 32'h0BAD_F00D, 31'd0, 1'b0});
	endtask

	// Random traffic under the smallest, largest, zero, a random and the reset step.
	task automatic test_step_settings();
		logic [STEP_W-1:0] steps [5];
		steps = '{16'd1, 16'hFFFF, 16'd0, STEP_W'($urandom_range(2, 65534)), TICK_STEP_RESET};
		foreach (steps[s]) begin
			write_step(steps[s]);
			run_random(150, 40, 15, 25);
		end
	endtask

	// Mixed traffic: an add-heavy stretch drives the table toward full, then a balanced mix.
	task automatic test_random_traffic();
		write_step(STEP_W'($urandom_range(1000, 9000)));
		run_random(150, 60, 5, 20);
		run_random(300, 35, 15, 30);
	endtask

	// Compares one accepted answer with the oldest one owed.
	function automatic void check_answer();
		answer_t want;
		if (pending_answers.size() == 0) begin
			$error("unexpected answer: status %0d, slot %0d", rsp_ch.status, rsp_ch.slot);
			errors++;
			return;
		end
		want = pending_answers.pop_front();
		if (rsp_ch.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
			errors++;
		end
		if (rsp_ch.hit !== want.hit) begin
			$error("hit: expected %0d, got %0d", want.hit, rsp_ch.hit);
			errors++;
		end
		if (rsp_ch.slot !== want.slot) begin
			$error("slot: expected %0d, got %0d", want.slot, rsp_ch.slot);
			errors++;
		end
		if (rsp_ch.expired_count !== want.expired_count) begin
			$error("expired_count: expected %0d, got %0d", want.expired_count,
				rsp_ch.expired_count);
			errors++;
		end
	endfunction

	// Answer side: while gaps are on, ready drops after each answer for a random wait, possibly none.
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			check_answer();
			rsp_stall = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
		end
		if (rsp_stall > 0) begin
			rsp_stall--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Ends the run if no item moves on either channel for too long.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		step_we          = 1'b0;
		step_wdata       = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_ADD;
		req_ch.key       = '0;
		req_ch.duration  = '0;
		req_ch.permanent = 1'b0;
		rsp_ch.ready     = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			shadow_key[i]   = '0;
			shadow_valid[i] = 1'b0;
			shadow_perm[i]  = 1'b0;
			shadow_time[i]  = '0;
		end
		shadow_step = TICK_STEP_RESET;
		// The pool always holds the two extreme keys.
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The block runs a clearing pass after reset; the first item simply waits for it.
		test_directed();
		test_fill_table();
		test_step_settings();
		test_random_traffic();

		drop_req();
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
